// ----- rtl/wbps_pkg.sv -----
// wbps_pkg: shared types and constants of the wildcard byte signature scanner
// used by wbps_cfg_regs, wbps_cell and wildcard_byte_pattern_scan_unit
package wbps_pkg;

  localparam int BYTE_W    = 8;
  localparam int SIG_BYTES = 8;
  localparam int SIG_W     = SIG_BYTES * BYTE_W;
  localparam int LEN_W     = 4;
  localparam int SEL_W     = 3;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SIG_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_LEN   = 2'd2;

  localparam logic [SIG_W-1:0]     SIG_RST  = '0;
  localparam logic [SIG_BYTES-1:0] CARE_RST = '1;
  localparam logic [LEN_W-1:0]     LEN_RST  = 4'd1;

  typedef struct packed {
    logic [SIG_W-1:0]     sig_bytes;
    logic [SIG_BYTES-1:0] care_mask;
    logic [LEN_W-1:0]     act_len;
  } cfg_t;

endpackage

// ----- rtl/wbps_cfg_regs.sv -----
// wbps_cfg_regs: signature, care mask and length registers with length clamp
// depends on wbps_pkg
module wbps_cfg_regs #(
  parameter int MAX_SIGNATURE = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wbps_pkg::SIG_W-1:0]          cfg_data,
  output wbps_pkg::cfg_t                      cfg
);

  localparam logic [wbps_pkg::LEN_W-1:0] MAX_LEN = wbps_pkg::LEN_W'(MAX_SIGNATURE);

  logic [wbps_pkg::SIG_W-1:0]     sig_r, sig_nxt;
  logic [wbps_pkg::SIG_BYTES-1:0] care_r, care_nxt;
  logic [wbps_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic [wbps_pkg::LEN_W-1:0]     act_len;

  always_comb begin
    sig_nxt  = sig_r;
    care_nxt = care_r;
    len_nxt  = len_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        wbps_pkg::REG_SIG_BYTES: sig_nxt  = cfg_data;
        wbps_pkg::REG_CARE_MASK: care_nxt = cfg_data[wbps_pkg::SIG_BYTES-1:0];
        wbps_pkg::REG_SIG_LEN:   len_nxt  = cfg_data[wbps_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_r  <= wbps_pkg::SIG_RST;
      care_r <= wbps_pkg::CARE_RST;
      len_r  <= wbps_pkg::LEN_RST;
    end else begin
      sig_r  <= sig_nxt;
      care_r <= care_nxt;
      len_r  <= len_nxt;
    end
  end

  // zero length acts as one, long lengths clamp to the window depth
  always_comb begin
    if (len_r == '0) begin
      act_len = wbps_pkg::LEN_W'(1);
    end else if (len_r > MAX_LEN) begin
      act_len = MAX_LEN;
    end else begin
      act_len = len_r;
    end
  end

  assign cfg.sig_bytes = sig_r;
  assign cfg.care_mask = care_r;
  assign cfg.act_len   = act_len;

endmodule

// ----- rtl/wbps_cell.sv -----
// wbps_cell: one window byte of the scan chain and its masked byte compare
// depends on wbps_pkg
module wbps_cell #(
  parameter int IDX = 0
) (
  input  logic                            clk,
  input  logic                            shift_en,
  input  logic [wbps_pkg::BYTE_W-1:0]     byte_in,
  input  wbps_pkg::cfg_t                  cfg,
  output logic [wbps_pkg::BYTE_W-1:0]     byte_out,
  output logic                            hit
);

  logic [wbps_pkg::BYTE_W-1:0] byte_r;
  logic [wbps_pkg::LEN_W-1:0]  sel_full;
  logic [wbps_pkg::SEL_W-1:0]  sel;
  logic                        in_use;
  logic [wbps_pkg::BYTE_W-1:0] want;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  // compare against the byte this cell holds after the shift
  assign in_use   = wbps_pkg::LEN_W'(IDX) < cfg.act_len;
  assign sel_full = cfg.act_len - wbps_pkg::LEN_W'(IDX) - wbps_pkg::LEN_W'(1);
  assign sel      = sel_full[wbps_pkg::SEL_W-1:0];
  assign want     = cfg.sig_bytes[sel*wbps_pkg::BYTE_W +: wbps_pkg::BYTE_W];
  assign hit      = !in_use || !cfg.care_mask[sel] || (want == byte_in);
  assign byte_out = byte_r;

endmodule

// ----- rtl/wildcard_byte_pattern_scan_unit.sv -----
// wildcard_byte_pattern_scan_unit: masked byte signature scanner, top level
// depends on wbps_pkg, wbps_cfg_regs and wbps_cell
//
// bytes of a memory image enter on the in_ channel, one item per cycle when
// the result side is not stalled. a row of window cells shifts each byte on
// and compares every held byte against its signature byte at once, so any
// match ending on the current byte is seen in the cycle the byte arrives.
// nothing comes out for ordinary bytes; the item with in_last_byte set makes
// one result (out_found, out_match_offset) appear in the output register
// in the cycle after it is accepted, and the scan state clears for the next scan.
// throughput is one byte per cycle while in_ready is high, set by the combinational window compare.
// in_ready drops only while a result sits in the output register and
// out_ready is low. registers are written over cfg_ at any time, taking
// effect from the next byte; cfg_ready is always high.
// reset (rst_n low at a clock edge) restores the register defaults, clears
// the byte count and any recorded match and empties the output register.
module wildcard_byte_pattern_scan_unit #(
  parameter int MAX_SIGNATURE = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [wbps_pkg::BYTE_W-1:0]        in_data_byte,
  input  logic                               in_last_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output logic [wbps_pkg::CNT_W-1:0]         out_match_offset,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wbps_pkg::SIG_W-1:0]         cfg_data
);

  wbps_pkg::cfg_t cfg;

  logic                        accept;
  logic [MAX_SIGNATURE-1:0]    hits;
  logic [wbps_pkg::BYTE_W-1:0] win_byte [MAX_SIGNATURE];
  logic                        win_match;

  logic [wbps_pkg::CNT_W-1:0]  bytes_seen_r, bytes_seen_nxt;
  logic                        have_match_r, have_match_nxt;
  logic [wbps_pkg::CNT_W-1:0]  first_offset_r, first_offset_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_found_r, out_found_nxt;
  logic [wbps_pkg::CNT_W-1:0]  out_offset_r, out_offset_nxt;

  logic                        cnt_sat;
  logic [wbps_pkg::LEN_W-1:0]  len_m1;
  logic [wbps_pkg::LEN_W-1:0]  sub_len;
  logic                        reach;
  logic [wbps_pkg::CNT_W-1:0]  cnt_inc;
  logic [wbps_pkg::CNT_W-1:0]  offset_cand;
  logic                        new_hit;
  logic                        hm_upd;
  logic [wbps_pkg::CNT_W-1:0]  fo_upd;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;

  wbps_cfg_regs #(
    .MAX_SIGNATURE(MAX_SIGNATURE)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  for (genvar j = 0; j < MAX_SIGNATURE; j++) begin : g_cell
    logic [wbps_pkg::BYTE_W-1:0] cell_in;
    if (j == 0) begin : g_head
      assign cell_in = in_data_byte;
    end else begin : g_link
      assign cell_in = win_byte[j-1];
    end
    wbps_cell #(
      .IDX(j)
    ) u_cell (
      .clk     (clk),
      .shift_en(accept),
      .byte_in (cell_in),
      .cfg     (cfg),
      .byte_out(win_byte[j]),
      .hit     (hits[j])
    );
  end

  assign win_match = &hits;

  // count after this byte is bytes_seen + 1 unless saturated
  assign cnt_sat     = &bytes_seen_r;
  assign len_m1      = cfg.act_len - wbps_pkg::LEN_W'(1);
  assign reach       = bytes_seen_r >= wbps_pkg::CNT_W'(len_m1);
  assign sub_len     = cnt_sat ? cfg.act_len : len_m1;
  assign offset_cand = bytes_seen_r - wbps_pkg::CNT_W'(sub_len);
  assign cnt_inc     = cnt_sat ? bytes_seen_r : bytes_seen_r + wbps_pkg::CNT_W'(1);
  assign new_hit     = !have_match_r && reach && win_match;
  assign hm_upd      = have_match_r || new_hit;
  assign fo_upd      = new_hit ? offset_cand : first_offset_r;

  always_comb begin
    bytes_seen_nxt   = bytes_seen_r;
    have_match_nxt   = have_match_r;
    first_offset_nxt = first_offset_r;
    out_valid_nxt    = out_valid_r;
    out_found_nxt    = out_found_r;
    out_offset_nxt   = out_offset_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      if (in_last_byte) begin
        bytes_seen_nxt   = '0;
        have_match_nxt   = 1'b0;
        first_offset_nxt = '0;
        out_valid_nxt    = 1'b1;
        out_found_nxt    = hm_upd;
        out_offset_nxt   = hm_upd ? fo_upd : '0;
      end else begin
        bytes_seen_nxt   = cnt_inc;
        have_match_nxt   = hm_upd;
        first_offset_nxt = fo_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r   <= '0;
      have_match_r   <= 1'b0;
      first_offset_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      bytes_seen_r   <= bytes_seen_nxt;
      have_match_r   <= have_match_nxt;
      first_offset_r <= first_offset_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r  <= out_found_nxt;
    out_offset_r <= out_offset_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_match_offset = out_offset_r;

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_byte |=> out_valid)
    else $error("last item did not produce a result");

  a_last_clears_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_byte |=> bytes_seen_r == '0 && !have_match_r)
    else $error("scan state not cleared after last item");

  a_offset_zero_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_offset == '0)
    else $error("nonzero offset without a match");

  a_offset_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    have_match_r |-> first_offset_r < bytes_seen_r)
    else $error("recorded match offset beyond bytes seen");

endmodule
